### hw/rtl/lz4bd_pkg.sv
// Shared types and constants for the LZ4 block decoder.
package lz4bd_pkg;

  // Parser phase, one-hot.
  typedef enum logic [7:0] {
    PH_TOKEN   = 8'b0000_0001,
    PH_LITEXT  = 8'b0000_0010,
    PH_LITERAL = 8'b0000_0100,
    PH_OFFLO   = 8'b0000_1000,
    PH_OFFHI   = 8'b0001_0000,
    PH_MATEXT  = 8'b0010_0000,
    PH_DRAIN   = 8'b0100_0000,
    PH_SKIP    = 8'b1000_0000
  } phase_t;

  // Result status codes.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_TRUNC  = 2'd1;
  localparam logic [1:0] ST_BADOFF = 2'd2;
  localparam logic [1:0] ST_BUSY   = 2'd3;

  // Input word kinds.
  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // Token and length-extension codes.
  localparam logic [3:0] NIB_EXT      = 4'hF;
  localparam logic [7:0] LEN_EXT_CONT = 8'hFF;
  localparam int unsigned MIN_MATCH   = 4;

  typedef struct packed {
    logic       mode;
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic       out_valid;
    logic [7:0] out_byte;
    logic       byte_taken;
    logic       match_pending;
    logic       block_done;
    logic [1:0] status;
  } out_item_t;

  // What the parser hands to the history stage for one accepted word.
  typedef struct packed {
    out_item_t res;
    logic      rd_en;
    logic      wr_en;
  } issue_t;

endpackage

### hw/rtl/lz4bd_parse.sv
// Sequence parser: token, lengths, offset and match bookkeeping.
module lz4bd_parse
  import lz4bd_pkg::*;
#(
  parameter int unsigned WINDOW_BYTES = 65536,
  parameter int unsigned LENGTH_BITS  = 32,
  parameter int unsigned AW           = $clog2(WINDOW_BYTES)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          acc,
  input  in_item_t      in_data,
  output issue_t        issue,
  output logic [AW-1:0] rd_addr,
  output logic [AW-1:0] wr_addr
);

  localparam int unsigned PW = $clog2(WINDOW_BYTES + 1);
  localparam int unsigned LB = LENGTH_BITS;

  phase_t        phase_r, phase_nxt;
  logic [LB-1:0] lit_left_r, lit_left_nxt;
  logic [LB-1:0] match_left_r, match_left_nxt;
  logic [15:0]   dist_r, dist_nxt;
  logic [3:0]    nib_r, nib_nxt;
  logic [PW-1:0] produced_r, produced_nxt;
  logic [AW-1:0] wp_r, wp_nxt;
  logic [1:0]    err_r, err_nxt;
  logic          end_seen_r, end_seen_nxt;

  logic [LB:0]   lit_sum, mat_sum, mat_sum4;
  logic [LB-1:0] lit_sat, mat_sat, mat_sat4;
  logic [15:0]   dist_hi;
  logic          bad_hi, bad_cur;
  logic          store, done;
  logic [7:0]    b;

  assign b = in_data.in_byte;

  // Saturating length adds: all ones is the ceiling, so carry out means clamp.
  assign lit_sum  = {1'b0, lit_left_r} + (LB+1)'(b);
  assign mat_sum  = {1'b0, match_left_r} + (LB+1)'(b);
  assign mat_sum4 = {1'b0, match_left_r} + (LB+1)'(b) + (LB+1)'(MIN_MATCH);
  assign lit_sat  = lit_sum[LB]  ? {LB{1'b1}} : lit_sum[LB-1:0];
  assign mat_sat  = mat_sum[LB]  ? {LB{1'b1}} : mat_sum[LB-1:0];
  assign mat_sat4 = mat_sum4[LB] ? {LB{1'b1}} : mat_sum4[LB-1:0];

  assign dist_hi = {b, dist_r[7:0]};
  assign bad_hi  = (dist_hi == 16'd0) || (32'(dist_hi) > 32'(produced_r)) ||
                   (32'(dist_hi) > WINDOW_BYTES);
  assign bad_cur = (dist_r == 16'd0) || (32'(dist_r) > 32'(produced_r)) ||
                   (32'(dist_r) > WINDOW_BYTES);

  // Copy source sits dist bytes behind the write pointer, modulo the window.
  always_comb begin
    if (32'(wp_r) >= 32'(dist_r)) begin
      rd_addr = AW'(32'(wp_r) - 32'(dist_r));
    end else begin
      rd_addr = AW'(32'(wp_r) + WINDOW_BYTES - 32'(dist_r));
    end
  end

  assign wr_addr = wp_r;

  always_comb begin
    phase_nxt      = phase_r;
    lit_left_nxt   = lit_left_r;
    match_left_nxt = match_left_r;
    dist_nxt       = dist_r;
    nib_nxt        = nib_r;
    produced_nxt   = produced_r;
    wp_nxt         = wp_r;
    err_nxt        = err_r;
    end_seen_nxt   = end_seen_r;
    store          = 1'b0;
    done           = 1'b0;
    issue          = '0;
    issue.res.status = err_r;

    if (in_data.mode == MODE_TICK) begin
      if (phase_r == PH_DRAIN) begin
        issue.res.out_valid = 1'b1;
        issue.rd_en         = 1'b1;
        issue.wr_en         = 1'b1;
        store               = 1'b1;
        match_left_nxt      = match_left_r - 1'b1;
        if (match_left_r == LB'(1)) begin
          if (end_seen_r) begin
            done = 1'b1;
          end else begin
            phase_nxt = PH_TOKEN;
          end
        end
      end
    end else if (phase_r == PH_DRAIN) begin
      // refuse the byte, leave state alone
      issue.res.status = ST_BUSY;
    end else begin
      issue.res.byte_taken = 1'b1;
      unique case (phase_r)
        PH_TOKEN: begin
          lit_left_nxt = LB'(b[7:4]);
          nib_nxt      = b[3:0];
          if (b[7:4] == NIB_EXT) begin
            phase_nxt = PH_LITEXT;
          end else if (b[7:4] != 4'd0) begin
            phase_nxt = PH_LITERAL;
          end else begin
            phase_nxt = PH_OFFLO;
          end
        end
        PH_LITEXT: begin
          lit_left_nxt = lit_sat;
          if (b != LEN_EXT_CONT) begin
            phase_nxt = PH_LITERAL;
          end
        end
        PH_LITERAL: begin
          issue.res.out_valid = 1'b1;
          issue.res.out_byte  = b;
          issue.wr_en         = 1'b1;
          store               = 1'b1;
          lit_left_nxt        = lit_left_r - 1'b1;
          if (lit_left_r == LB'(1)) begin
            phase_nxt = PH_OFFLO;
          end
        end
        PH_OFFLO: begin
          dist_nxt  = {8'd0, b};
          phase_nxt = PH_OFFHI;
        end
        PH_OFFHI: begin
          dist_nxt = dist_hi;
          if (nib_r == NIB_EXT) begin
            match_left_nxt = LB'(NIB_EXT);
            phase_nxt      = PH_MATEXT;
          end else begin
            match_left_nxt = LB'(nib_r) + LB'(MIN_MATCH);
            if (bad_hi) begin
              err_nxt   = ST_BADOFF;
              phase_nxt = PH_SKIP;
            end else begin
              phase_nxt = PH_DRAIN;
            end
          end
        end
        PH_MATEXT: begin
          if (b != LEN_EXT_CONT) begin
            match_left_nxt = mat_sat4;
            if (bad_cur) begin
              err_nxt   = ST_BADOFF;
              phase_nxt = PH_SKIP;
            end else begin
              phase_nxt = PH_DRAIN;
            end
          end else begin
            match_left_nxt = mat_sat;
          end
        end
        default: begin
          // skipping after an error: swallow the byte
        end
      endcase

      if (in_data.in_last) begin
        if (phase_nxt == PH_DRAIN) begin
          end_seen_nxt = 1'b1;
        end else begin
          if (phase_nxt != PH_OFFLO && phase_nxt != PH_SKIP) begin
            err_nxt = ST_TRUNC;
          end
          done = 1'b1;
        end
      end
      issue.res.status = err_nxt;
    end

    if (store) begin
      wp_nxt = (32'(wp_r) == WINDOW_BYTES - 1) ? '0 : wp_r + 1'b1;
      if (32'(produced_r) < WINDOW_BYTES) begin
        produced_nxt = produced_r + 1'b1;
      end
    end

    if (done) begin
      phase_nxt      = PH_TOKEN;
      lit_left_nxt   = '0;
      match_left_nxt = '0;
      dist_nxt       = '0;
      nib_nxt        = '0;
      produced_nxt   = '0;
      err_nxt        = ST_OK;
      end_seen_nxt   = 1'b0;
    end

    issue.res.block_done    = done;
    issue.res.match_pending = (phase_nxt == PH_DRAIN);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_TOKEN;
      lit_left_r   <= '0;
      match_left_r <= '0;
      dist_r       <= '0;
      nib_r        <= '0;
      produced_r   <= '0;
      wp_r         <= '0;
      err_r        <= ST_OK;
      end_seen_r   <= 1'b0;
    end else if (acc) begin
      phase_r      <= phase_nxt;
      lit_left_r   <= lit_left_nxt;
      match_left_r <= match_left_nxt;
      dist_r       <= dist_nxt;
      nib_r        <= nib_nxt;
      produced_r   <= produced_nxt;
      wp_r         <= wp_nxt;
      err_r        <= err_nxt;
      end_seen_r   <= end_seen_nxt;
    end
  end

endmodule

### hw/rtl/lz4bd_hist.sv
// History window memory with the copy stage and write-to-read forwarding.
module lz4bd_hist
  import lz4bd_pkg::*;
#(
  parameter int unsigned WINDOW_BYTES = 65536,
  parameter int unsigned AW           = $clog2(WINDOW_BYTES)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          acc,
  input  logic          s1_adv,
  input  issue_t        issue,
  input  logic [AW-1:0] rd_addr,
  input  logic [AW-1:0] wr_addr,
  output logic          s1_valid,
  output out_item_t     s1_res
);

  logic [7:0]    mem [WINDOW_BYTES];

  logic          s1_valid_r;
  out_item_t     s1_item_r;
  logic          s1_rd_r;
  logic          s1_wr_r;
  logic [AW-1:0] s1_waddr_r;
  logic [7:0]    rd_data_r;
  logic          fwd_hit_r;
  logic [7:0]    fwd_data_r;
  logic [7:0]    s1_byte;
  logic          wr_fire;

  // The read issued at accept misses only the write retiring on the same edge.
  assign s1_byte = !s1_rd_r ? s1_item_r.out_byte :
                   (fwd_hit_r ? fwd_data_r : rd_data_r);
  assign wr_fire = s1_adv && s1_valid_r && s1_wr_r;

  always_ff @(posedge clk) begin
    if (wr_fire) begin
      mem[s1_waddr_r] <= s1_byte;
    end
    if (acc && issue.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_item_r  <= issue.res;
      s1_rd_r    <= issue.rd_en;
      s1_wr_r    <= issue.wr_en;
      s1_waddr_r <= wr_addr;
      fwd_hit_r  <= wr_fire && (s1_waddr_r == rd_addr);
      fwd_data_r <= s1_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_comb begin
    s1_res          = s1_item_r;
    s1_res.out_byte = s1_byte;
  end

  assign s1_valid = s1_valid_r;

endmodule

### hw/rtl/lz4_block_decompressor_top.sv
// Top level of the LZ4 raw block decoder.
//
//  channel | direction | handshake            | word
//  --------+-----------+----------------------+-----------------------------------
//  in_     | input     | in_valid / in_stall  | in_item_t: mode, in_byte, in_last
//  out_    | output    | out_valid / out_stall| out_item_t: one result per in word
//
//  One word per cycle while out_stall is low; a word's result passes the copy
//  stage register and then the output register on its way to out_.
//  The rate is set by the history memory: one read at accept and one
//  write in the copy stage each cycle, with the same-edge write forwarded.
//  Reset clears the parser and the pipeline; the history window is not cleared.
//  out_stall holds the output register, then the copy stage, then in_stall.
module lz4_block_decompressor_top
  import lz4bd_pkg::*;
#(
  parameter int unsigned WINDOW_BYTES = 65536,
  parameter int unsigned LENGTH_BITS  = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int unsigned AW = $clog2(WINDOW_BYTES);

  issue_t        issue;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          acc;
  logic          s1_valid;
  logic          s1_adv;
  out_item_t     s1_res;
  logic          out_valid_r;
  out_item_t     out_data_r;

  assign s1_adv   = s1_valid && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid && !s1_adv;
  assign acc      = in_valid && !in_stall;

  lz4bd_parse #(
    .WINDOW_BYTES (WINDOW_BYTES),
    .LENGTH_BITS  (LENGTH_BITS),
    .AW           (AW)
  ) u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .in_data (in_data),
    .issue   (issue),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr)
  );

  lz4bd_hist #(
    .WINDOW_BYTES (WINDOW_BYTES),
    .AW           (AW)
  ) u_hist (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .s1_adv   (s1_adv),
    .issue    (issue),
    .rd_addr  (rd_addr),
    .wr_addr  (wr_addr),
    .s1_valid (s1_valid),
    .s1_res   (s1_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= s1_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### hw/rtl/lz4bd_checker.sv
// Port-level checks for the LZ4 block decoder, bound to the top level.
module lz4bd_checker
  import lz4bd_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // Hold a stalled result word.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result word changed");

  // The pipeline is empty the cycle after reset, so input is open.
  a_reset_open: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled right after reset");

  // A refused byte only happens while a match is pending.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == ST_BUSY |->
      !out_data.byte_taken && out_data.match_pending && !out_data.out_valid)
    else $error("refused byte without pending match");

  // A finished block leaves no match behind.
  a_done_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.block_done |-> !out_data.match_pending)
    else $error("block finished with match pending");

  // Without a produced byte the byte field is zero.
  a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.out_valid |-> out_data.out_byte == 8'd0)
    else $error("stray byte on empty result");

endmodule

bind lz4_block_decompressor_top lz4bd_checker u_chk (.*);
